// ===== rtl/core/neuron_mac_activation_assert.svh =====
// ----------------------------------------------------------------------------
// Neuron MAC assertion macros
// Short forms for the concurrent checks of the neuron datapath.
// ----------------------------------------------------------------------------
`ifndef NEURON_MAC_ACTIVATION_ASSERT_SVH
`define NEURON_MAC_ACTIVATION_ASSERT_SVH

// Same-cycle implication, disabled while reset is applied.
`define NMA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is applied.
`define NMA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/nma_pkg.sv =====
// ----------------------------------------------------------------------------
// Neuron MAC package
// Shared widths, fixed-point constants, codes, states and the exp2 table.
// ----------------------------------------------------------------------------
`default_nettype none

package nma_pkg;

	// Data format: signed Q4.12 on all 16-bit fields.
	localparam int DATA_W    = 16;
	localparam int FRAC_BITS = 12;
	localparam int ONE       = 1 << FRAC_BITS;
	localparam int HALF      = 1 << (FRAC_BITS - 1);
	localparam int DATA_MAX  = 32767;
	localparam int DATA_MIN  = -32768;

	// Accumulator default width.
	localparam int ACC_WIDTH_DEF = 40;

	// Shared multiplier operand and product widths.
	localparam int MUL_W  = 18;
	localparam int PROD_W = 2 * MUL_W;

	// Exp approximation: log2(e) in Q16, mantissa and scaled result widths.
	localparam int LOG2E_Q16 = 94548;
	localparam int EXP_M_W   = 18;
	localparam int EXP_W     = 25;

	// Leaky slope numerator over 2^FRAC_BITS and the matching derivative.
	localparam int LEAKY_NUM   = 41;
	localparam int LEAKY_DERIV = (ONE * LEAKY_NUM + HALF) >> FRAC_BITS;

	// Divider operand widths for sigmoid and tanh.
	localparam int DIV_NUM_W = 25;
	localparam int DIV_DEN_W = 14;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS = 2'd1;

	// Activation mode codes; any other code behaves as linear.
	localparam logic [2:0] MODE_SIGMOID = 3'd0;
	localparam logic [2:0] MODE_TANH    = 3'd1;
	localparam logic [2:0] MODE_RELU    = 3'd2;
	localparam logic [2:0] MODE_LEAKY   = 3'd3;
	localparam logic [2:0] MODE_LINEAR  = 3'd4;
	localparam logic [2:0] MODE_EXP     = 3'd5;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MAC,
		ST_BIAS,
		ST_SEL,
		ST_EXPL,
		ST_EXPS,
		ST_EPOST,
		ST_DIVW,
		ST_DERM,
		ST_DER,
		ST_LEAKR,
		ST_OUT
	} nma_state_t;

	// 2^(k/16) in Q16 for k = 0..16.
	function automatic logic [EXP_M_W-1:0] exp2_q16(input logic [4:0] idx);
		logic [EXP_M_W-1:0] val;
		case (idx)
			5'd0:    val = 18'd65536;
			5'd1:    val = 18'd68438;
			5'd2:    val = 18'd71468;
			5'd3:    val = 18'd74632;
			5'd4:    val = 18'd77936;
			5'd5:    val = 18'd81386;
			5'd6:    val = 18'd84990;
			5'd7:    val = 18'd88752;
			5'd8:    val = 18'd92682;
			5'd9:    val = 18'd96785;
			5'd10:   val = 18'd101070;
			5'd11:   val = 18'd105545;
			5'd12:   val = 18'd110218;
			5'd13:   val = 18'd115098;
			5'd14:   val = 18'd120194;
			5'd15:   val = 18'd125515;
			default: val = 18'd131072;
		endcase
		return val;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/nma_in_if.sv =====
// ----------------------------------------------------------------------------
// Neuron MAC element channel
// Valid/ready channel carrying one input and weight pair per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface nma_in_if;
	import nma_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] input_value;
	logic signed [DATA_W-1:0] weight_value;
	logic                     last_element;

	modport source (
		output valid, input_value, weight_value, last_element,
		input  ready
	);

	modport sink (
		input  valid, input_value, weight_value, last_element,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/core/nma_out_if.sv =====
// ----------------------------------------------------------------------------
// Neuron MAC result channel
// Valid/ready channel carrying one activated result per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface nma_out_if;
	import nma_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] activation_out;
	logic signed [DATA_W-1:0] derivative_out;
	logic                     saturated;

	modport source (
		output valid, activation_out, derivative_out, saturated,
		input  ready
	);

	modport sink (
		input  valid, activation_out, derivative_out, saturated,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/core/nma_mul.sv =====
// ----------------------------------------------------------------------------
// Neuron MAC shared multiplier
// Signed 18 x 18 multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module nma_mul (
	input  logic                              clk,
	input  logic signed [nma_pkg::MUL_W-1:0]  op_a,
	input  logic signed [nma_pkg::MUL_W-1:0]  op_b,
	output logic signed [nma_pkg::PROD_W-1:0] prod
);
	import nma_pkg::*;

	// The product is registered: it lands in the cycle after the operands are presented.
	always_ff @(posedge clk) begin
		prod <= op_a * op_b;
	end
endmodule

`default_nettype wire

// ===== rtl/core/nma_div.sv =====
// ----------------------------------------------------------------------------
// Neuron MAC divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module nma_div #(
	parameter int NUM_W = nma_pkg::DIV_NUM_W,
	parameter int DEN_W = nma_pkg::DIV_DEN_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic [NUM_W-1:0] quo
);
	import nma_pkg::*;

	localparam int CNT_W = $clog2(NUM_W);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   trial_sub;
	logic             fits;

	// Shift the next dividend bit into the remainder and try a subtract.
	always_comb begin
		trial     = {rem_q, quo_q[NUM_W-1]};
		trial_sub = trial - {1'b0, den_q};
		fits      = (trial >= {1'b0, den_q});
	end

	// Control: busy from the start edge until the last quotient bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(NUM_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Datapath: the dividend shifts out as the quotient shifts in.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;
endmodule

`default_nettype wire

// ===== rtl/core/neuron_mac_activation.sv =====
// ----------------------------------------------------------------------------
// Neuron multiply-accumulate with activation
// Accumulates input x weight products, then adds the bias and applies the
// selected activation, giving the output, its derivative and a clip flag.
// ----------------------------------------------------------------------------
//
//  Channel  | Dir | Beat contents
//  ---------+-----+------------------------------------------------------
//  elem     | in  | input_value, weight_value, last_element (Q4.12)
//  result   | out | activation_out, derivative_out, saturated (Q4.12)
//  cfg_*    | in  | write of activation_mode (index 0) or bias_value (1)
//
//  Beats that do not close the vector can follow each other every cycle
//  through the shared multiplier. A closing beat runs the sequencer: bias,
//  select, then result for relu, linear and a positive leaky sum; a leaky
//  sum at or below zero adds a rescale; exp adds lookup, scale, post and
//  derivative steps; sigmoid and tanh also wait on the 25-step divider.
//  No new beat is taken from the closing beat until its result is taken.
//  Reset clears the accumulator, the configuration registers and the sequencer.
//
`default_nettype none

`include "neuron_mac_activation_assert.svh"

module neuron_mac_activation #(
	parameter int ACC_WIDTH = nma_pkg::ACC_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	nma_in_if.sink                               elem,
	nma_out_if.source                            result,
	input  logic                                 cfg_we,
	input  logic [nma_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [nma_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import nma_pkg::*;

	localparam int AW    = ACC_WIDTH;
	localparam int BS_W  = AW + 2;
	localparam int RND_W = BS_W - FRAC_BITS;

	localparam logic signed [AW-1:0]    ACC_MAX = {1'b0, {(AW-1){1'b1}}};
	localparam logic signed [AW-1:0]    ACC_MIN = {1'b1, {(AW-1){1'b0}}};
	localparam logic signed [RND_W-1:0] RND_MAX = RND_W'(DATA_MAX);
	localparam logic signed [RND_W-1:0] RND_MIN = RND_W'(DATA_MIN);
	localparam logic signed [24:0]      DER_MAX = 25'(DATA_MAX);
	localparam logic signed [24:0]      DER_MIN = 25'(DATA_MIN);

	nma_state_t state_q, state_d;

	// Registers and working state.
	logic [2:0]               mode_q;
	logic signed [DATA_W-1:0] bias_q;
	logic signed [AW-1:0]     acc_q;
	logic                     last_q;
	logic signed [DATA_W-1:0] x_q;
	logic                     clip_q;
	logic signed [7:0]        n_q;
	logic [3:0]               i_q;
	logic [EXP_W-1:0]         e_q;
	logic signed [DATA_W-1:0] o_q;
	logic signed [DATA_W-1:0] d_q;

	// Shared units.
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] mul_p;
	logic                     div_start, div_busy;
	logic [DIV_NUM_W-1:0]     div_num, div_quo;
	logic [DIV_DEN_W-1:0]     div_den;

	logic elem_acc;

	// Working values.
	logic signed [31:0]          prod32;
	logic signed [AW:0]          mac_sum;
	logic signed [AW-1:0]        mac_sat;
	logic signed [BS_W-1:0]      bias_ext, bias_sum;
	logic signed [RND_W-1:0]     bias_rnd;
	logic signed [DATA_W-1:0]    x_nxt;
	logic                        x_of;
	logic [16:0]                 ax;
	logic signed [MUL_W-1:0]     exp_arg, x18, o18;
	logic [4:0]                  idx_lo, idx_hi;
	logic [EXP_M_W-1:0]          lerp_diff;
	logic [EXP_M_W-1:0]          mant;
	logic signed [7:0]           sh, neg_sh;
	logic [EXP_W-1:0]            e_nxt;
	logic [12:0]                 e13;
	logic [DATA_W-1:0]           q16;
	logic signed [PROD_W-1:0]    p_rnd;
	logic [23:0]                 p_hi;
	logic signed [24:0]          d_wide;
	logic signed [DATA_W-1:0]    d_nxt;

	nma_mul u_mul (
		.clk  (clk),
		.op_a (mul_a),
		.op_b (mul_b),
		.prod (mul_p)
	);

	nma_div #(
		.NUM_W (DIV_NUM_W),
		.DEN_W (DIV_DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quo    (div_quo)
	);

	assign elem_acc = elem.valid && elem.ready;

	// Accumulate the product into the accumulator, saturating at its bounds.
	always_comb begin
		prod32  = mul_p[31:0];
		mac_sum = {acc_q[AW-1], acc_q} + {{(AW+1-32){prod32[31]}}, prod32};
		if (mac_sum[AW] != mac_sum[AW-1]) begin
			mac_sat = mac_sum[AW] ? ACC_MIN : ACC_MAX;
		end else begin
			mac_sat = mac_sum[AW-1:0];
		end
	end

	// Add the bias, round to the data format and clip to 16 bits.
	always_comb begin
		bias_ext = {{(BS_W-DATA_W-FRAC_BITS){bias_q[DATA_W-1]}}, bias_q,
			{FRAC_BITS{1'b0}}};
		bias_sum = {{2{acc_q[AW-1]}}, acc_q} + bias_ext + BS_W'(HALF);
		bias_rnd = bias_sum[BS_W-1:FRAC_BITS];
		x_of     = (bias_rnd > RND_MAX) || (bias_rnd < RND_MIN);
		if (bias_rnd > RND_MAX) begin
			x_nxt = 16'sh7fff;
		end else if (bias_rnd < RND_MIN) begin
			x_nxt = 16'sh8000;
		end else begin
			x_nxt = bias_rnd[DATA_W-1:0];
		end
	end

	// Exp argument: -|x| for sigmoid, -2|x| for tanh, x for exp.
	always_comb begin
		x18 = {{(MUL_W-DATA_W){x_q[DATA_W-1]}}, x_q};
		ax  = x_q[DATA_W-1] ? (17'd0 - {x_q[DATA_W-1], x_q}) : {x_q[DATA_W-1], x_q};
		case (mode_q)
			MODE_SIGMOID: exp_arg = 18'sd0 - $signed({1'b0, ax});
			MODE_TANH:    exp_arg = 18'sd0 - $signed({ax, 1'b0});
			default:      exp_arg = x18;
		endcase
	end

	// Exp table lookup, interpolation and scaling by the integer part.
	always_comb begin
		idx_lo    = {1'b0, mul_p[27:24]};
		idx_hi    = idx_lo + 5'd1;
		lerp_diff = exp2_q16(idx_hi) - exp2_q16(idx_lo);
		mant      = exp2_q16({1'b0, i_q}) + {5'd0, mul_p[24:12]};
		sh        = n_q - 8'sd4;
		neg_sh    = 8'sd0 - sh;
		if (sh[7]) begin
			e_nxt = {7'd0, mant} >> neg_sh[4:0];
		end else begin
			e_nxt = {7'd0, mant} << sh[2:0];
		end
	end

	// Divider operands and quotient handling for sigmoid and tanh.
	always_comb begin
		e13     = e_q[12:0];
		div_den = {1'b0, e13} + 14'(ONE);
		if (mode_q == MODE_TANH) begin
			div_num = {13'(ONE) - e13, 12'd0} + {12'd0, div_den[13:1]};
		end else begin
			div_num = {e13, 12'd0} + {12'd0, div_den[13:1]};
		end
		q16 = {3'd0, div_quo[12:0]};
	end

	// Round the registered product and form the derivative.
	always_comb begin
		o18   = {{(MUL_W-DATA_W){o_q[DATA_W-1]}}, o_q};
		p_rnd = mul_p + PROD_W'(HALF);
		p_hi  = p_rnd[PROD_W-1:FRAC_BITS];
		if (mode_q == MODE_TANH) begin
			d_wide = 25'(ONE) - $signed({p_hi[23], p_hi});
		end else begin
			d_wide = {p_hi[23], p_hi};
		end
		if (d_wide > DER_MAX) begin
			d_nxt = 16'sh7fff;
		end else if (d_wide < DER_MIN) begin
			d_nxt = 16'sh8000;
		end else begin
			d_nxt = d_wide[DATA_W-1:0];
		end
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, handshakes and multiplier operand selection.
	always_comb begin
		state_d      = state_q;
		elem.ready   = 1'b0;
		result.valid = 1'b0;
		div_start    = 1'b0;
		mul_a        = {{(MUL_W-DATA_W){elem.input_value[DATA_W-1]}}, elem.input_value};
		mul_b        = {{(MUL_W-DATA_W){elem.weight_value[DATA_W-1]}}, elem.weight_value};
		case (state_q)
			ST_IDLE: begin
				elem.ready = 1'b1;
				if (elem.valid) begin
					state_d = ST_MAC;
				end
			end
			ST_MAC: begin
				elem.ready = !last_q;
				if (last_q) begin
					state_d = ST_BIAS;
				end else if (elem.valid) begin
					state_d = ST_MAC;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_BIAS: begin
				state_d = ST_SEL;
			end
			ST_SEL: begin
				case (mode_q)
					MODE_SIGMOID, MODE_TANH, MODE_EXP: begin
						mul_a   = exp_arg;
						mul_b   = 18'(LOG2E_Q16);
						state_d = ST_EXPL;
					end
					MODE_LEAKY: begin
						mul_a   = x18;
						mul_b   = 18'(LEAKY_NUM);
						state_d = (x_q > 16'sd0) ? ST_OUT : ST_LEAKR;
					end
					default: begin
						state_d = ST_OUT;
					end
				endcase
			end
			ST_EXPL: begin
				mul_a   = lerp_diff;
				mul_b   = {6'd0, mul_p[23:12]};
				state_d = ST_EXPS;
			end
			ST_EXPS: begin
				state_d = ST_EPOST;
			end
			ST_EPOST: begin
				if (mode_q == MODE_EXP) begin
					state_d = ST_DERM;
				end else begin
					div_start = 1'b1;
					state_d   = ST_DIVW;
				end
			end
			ST_DIVW: begin
				if (!div_busy) begin
					state_d = ST_DERM;
				end
			end
			ST_DERM: begin
				mul_a   = o18;
				mul_b   = (mode_q == MODE_TANH) ? o18 : (18'(ONE) - o18);
				state_d = ST_DER;
			end
			ST_DER: begin
				state_d = ST_OUT;
			end
			ST_LEAKR: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				result.valid = 1'b1;
				if (result.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Configuration registers, accumulator and element tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SIGMOID;
			bias_q <= '0;
			acc_q  <= '0;
			last_q <= 1'b0;
		end else begin
			if (cfg_we && (cfg_index == REG_MODE)) begin
				mode_q <= cfg_data[2:0];
			end
			if (cfg_we && (cfg_index == REG_BIAS)) begin
				bias_q <= cfg_data;
			end
			if (elem_acc) begin
				last_q <= elem.last_element;
			end
			if (state_q == ST_MAC) begin
				acc_q <= mac_sat;
			end else if (state_q == ST_BIAS) begin
				acc_q <= '0;
			end
		end
	end

	// Activation datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_BIAS: begin
				x_q    <= x_nxt;
				clip_q <= x_of;
			end
			ST_SEL: begin
				case (mode_q)
					MODE_RELU: begin
						o_q <= (x_q > 16'sd0) ? x_q : '0;
						d_q <= (x_q > 16'sd0) ? 16'(ONE) : '0;
					end
					MODE_LEAKY: begin
						o_q <= x_q;
						d_q <= 16'(ONE);
					end
					default: begin
						o_q <= x_q;
						d_q <= 16'(ONE);
					end
				endcase
			end
			ST_EXPL: begin
				n_q <= mul_p[35:28];
				i_q <= mul_p[27:24];
			end
			ST_EXPS: begin
				e_q <= e_nxt;
			end
			ST_EPOST: begin
				if (mode_q == MODE_EXP) begin
					if (e_q > EXP_W'(DATA_MAX)) begin
						o_q    <= 16'sh7fff;
						clip_q <= 1'b1;
					end else begin
						o_q <= e_q[DATA_W-1:0];
					end
				end
			end
			ST_DIVW: begin
				if (!div_busy) begin
					if (mode_q == MODE_TANH) begin
						o_q <= x_q[DATA_W-1] ? (16'd0 - q16) : q16;
					end else begin
						o_q <= x_q[DATA_W-1] ? q16 : (16'(ONE) - q16);
					end
				end
			end
			ST_DER: begin
				d_q <= d_nxt;
			end
			ST_LEAKR: begin
				o_q <= p_rnd[FRAC_BITS+DATA_W-1:FRAC_BITS];
				d_q <= 16'(LEAKY_DERIV);
			end
			default: begin
			end
		endcase
	end

	assign result.activation_out = o_q;
	assign result.derivative_out = d_q;
	assign result.saturated      = clip_q;

	// The sequencer never takes an element while a result is waiting.
	`NMA_ASSERT_IMPL(a_no_elem_at_result, clk, arst_n, result.valid, !elem.ready, "elem ready")

	// The accumulator is cleared by the time a result is offered.
	`NMA_ASSERT_IMPL(a_acc_cleared, clk, arst_n, state_q == ST_OUT, acc_q == '0, "acc not clear")

	// The divider only runs while the sequencer waits on it.
	`NMA_ASSERT_IMPL(a_div_owned, clk, arst_n, div_busy, state_q == ST_DIVW, "div busy")

	// Every accepted element is accumulated in the next cycle.
	`NMA_ASSERT_NEXT(a_elem_to_mac, clk, arst_n, elem_acc, state_q == ST_MAC, "beat not accumulated")
endmodule

`default_nettype wire
